// File: rtl/cwb_pkg.sv
// Shared types, constants and the quarter-wave sine table for the beamformer.
package cwb_pkg;

    localparam int NUM_LANES    = 4;
    localparam int MAX_LOG2_FFT = 12;
    localparam int MIN_LOG2_FFT = 4;
    localparam int TW_FULL      = 1 << MAX_LOG2_FFT;
    localparam int TW_QUART     = TW_FULL / 4;
    localparam int TW_ADDR_W    = $clog2(TW_QUART + 1);
    localparam int TW_W         = 15;
    localparam int MAG_SUM_W    = 18;
    localparam int POW_W        = 38;
    localparam int QUO_W        = 18;

    // angle step is pi/2 per quarter, i.e. PI_Q30 * j / (2 * TW_QUART)
    localparam int ANGLE_SHIFT  = MAX_LOG2_FFT - 1;

    localparam logic [QUO_W-1:0] OUT_MAX = {QUO_W{1'b1}};

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LOG2_FFT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 1'b1;

    localparam logic [3:0] LOG2_FFT_RESET = 4'd9;
    localparam logic [2:0] CHANNELS_RESET = 3'd4;

    typedef logic [TW_W-1:0] sin_tab_t [0:TW_QUART];

    typedef struct packed {
        logic        [11:0] bin_index;
        logic signed [15:0] mic0_real;
        logic signed [15:0] mic0_imag;
        logic signed [15:0] mic1_real;
        logic signed [15:0] mic1_imag;
        logic signed [15:0] mic2_real;
        logic signed [15:0] mic2_imag;
        logic signed [15:0] mic3_real;
        logic signed [15:0] mic3_imag;
        logic signed [11:0] delay_mic1;
        logic signed [11:0] delay_mic2;
        logic signed [11:0] delay_mic3;
    } in_beat_t;

    typedef struct packed {
        logic [11:0] bin_out;
        logic [17:0] weighted_magnitude;
    } out_beat_t;

    // shift-subtract long division, used only while building the table
    function automatic longint unsigned udiv64(longint unsigned num,
                                               longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        int              i;
        rem = '0;
        quo = '0;
        for (i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], num[i]};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sin(pi/2 * j / quarter) in Q15, integer Taylor series in Q2.30
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t          t;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint unsigned   q;
        longint            acc;
        int                j;
        int                n;
        for (j = 0; j <= TW_QUART; j++)
        begin
            x    = (PI_Q30 * longint'(j)) >> ANGLE_SHIFT;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (n = 1; n <= 8; n++)
            begin
                term = udiv64((term * x2) >> 30, longint'((2 * n) * (2 * n + 1)));
                if ((n & 1) == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            q = (longint'(acc) + 64'd16384) >> 15;
            if (q > 64'd32767)
                q = 64'd32767;
            t[j] = q[TW_W-1:0];
        end
        return t;
    endfunction

endpackage

// File: rtl/cwb_sine_rom.sv
// Dual-read quarter-wave sine ROM with registered outputs.
module cwb_sine_rom (
    input  logic                          clk,
    input  logic                          en,
    input  logic [cwb_pkg::TW_ADDR_W-1:0] addr_a,
    input  logic [cwb_pkg::TW_ADDR_W-1:0] addr_b,
    output logic [cwb_pkg::TW_W-1:0]      data_a,
    output logic [cwb_pkg::TW_W-1:0]      data_b
);

    localparam cwb_pkg::sin_tab_t SIN_TAB = cwb_pkg::build_sin_tab();

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a <= SIN_TAB[addr_a];
            data_b <= SIN_TAB[addr_b];
        end
    end

endmodule

// File: rtl/cwb_isqrt.sv
// Four-stage rounded integer square root, four digit steps per stage.
module cwb_isqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] radicand,
    output logic [15:0] root
);

    logic [31:0] v_reg [0:2];
    logic [31:0] r_reg [0:2];
    logic [31:0] v_next [0:2];
    logic [31:0] r_next [0:2];
    logic [15:0] root_reg;
    logic [15:0] root_next;

    always_comb
    begin
        logic [31:0] v;
        logic [31:0] r;
        logic [31:0] b;
        for (int s = 0; s < 4; s++)
        begin
            if (s == 0)
            begin
                v = radicand;
                r = 32'd0;
            end
            else
            begin
                v = v_reg[s-1];
                r = r_reg[s-1];
            end
            for (int t = 0; t < 4; t++)
            begin
                b = 32'd1 << (30 - 2 * (4 * s + t));
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
            end
            if (s < 3)
            begin
                v_next[s] = v;
                r_next[s] = r;
            end
        end
        root_next = (v > r) ? 16'(r + 32'd1) : r[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < 3; s++)
            begin
                v_reg[s] <= v_next[s];
                r_reg[s] <= r_next[s];
            end
            root_reg <= root_next;
        end
    end

    assign root = root_reg;

endmodule

// File: rtl/cwb_divider.sv
// Pipelined restoring divide of beam power by magnitude sum, saturating.
module cwb_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [cwb_pkg::POW_W-1:0]     power,
    input  logic [cwb_pkg::MAG_SUM_W-1:0] mag_sum,
    input  logic [11:0]                   bin,
    output logic                          out_valid,
    output cwb_pkg::out_beat_t            out_data
);

    localparam int STEPS    = 3;
    localparam int NSTAGE   = cwb_pkg::QUO_W / STEPS;

    logic                          vld_reg  [0:NSTAGE];
    logic [cwb_pkg::POW_W-1:0]     rem_reg  [0:NSTAGE];
    logic [cwb_pkg::QUO_W-1:0]     quo_reg  [0:NSTAGE];
    logic [cwb_pkg::MAG_SUM_W-1:0] den_reg  [0:NSTAGE];
    logic                          zero_reg [0:NSTAGE];
    logic                          sat_reg  [0:NSTAGE];
    logic [11:0]                   bin_reg  [0:NSTAGE];

    logic [cwb_pkg::POW_W-1:0]     rem_next [1:NSTAGE];
    logic [cwb_pkg::QUO_W-1:0]     quo_next [1:NSTAGE];

    logic [cwb_pkg::POW_W-1:0]     den_top;

    assign den_top = cwb_pkg::POW_W'(mag_sum) << cwb_pkg::QUO_W;

    always_comb
    begin
        logic [cwb_pkg::POW_W-1:0] rem;
        logic [cwb_pkg::QUO_W-1:0] quo;
        logic [cwb_pkg::POW_W-1:0] dsh;
        for (int s = 1; s <= NSTAGE; s++)
        begin
            rem = rem_reg[s-1];
            quo = quo_reg[s-1];
            for (int t = 0; t < STEPS; t++)
            begin
                dsh = cwb_pkg::POW_W'(den_reg[s-1])
                      << (cwb_pkg::QUO_W - 1 - (STEPS * (s - 1) + t));
                if (rem >= dsh)
                begin
                    rem = rem - dsh;
                    quo[cwb_pkg::QUO_W - 1 - (STEPS * (s - 1) + t)] = 1'b1;
                end
            end
            rem_next[s] = rem;
            quo_next[s] = quo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NSTAGE; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= NSTAGE; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= power;
            quo_reg[0]  <= '0;
            den_reg[0]  <= mag_sum;
            zero_reg[0] <= (mag_sum == '0);
            sat_reg[0]  <= (power >= den_top);
            bin_reg[0]  <= bin;
            for (int s = 1; s <= NSTAGE; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                quo_reg[s]  <= quo_next[s];
                den_reg[s]  <= den_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                sat_reg[s]  <= sat_reg[s-1];
                bin_reg[s]  <= bin_reg[s-1];
            end
        end
    end

    assign out_valid        = vld_reg[NSTAGE];
    assign out_data.bin_out = bin_reg[NSTAGE];
    assign out_data.weighted_magnitude =
        zero_reg[NSTAGE] ? '0 : (sat_reg[NSTAGE] ? cwb_pkg::OUT_MAX : quo_reg[NSTAGE]);

endmodule

// File: rtl/coherence_weighted_delay_sum_beamformer.sv
// Top level: coherence-weighted delay-and-sum beamformer, one bin per beat.
//
// One frequency bin per clock: a beat carrying bin k, four complex mic
// values and three delays enters whenever in_ready is high and passes 13
// register stages before out_valid rises with the result, and the beat
// carries (bin, |sum|^2 / sum|x_c|). The whole pipeline moves on a
// single advance enable that drops only while a finished result is not
// taken, so the sustained rate is one bin per cycle. Stage 1 forms the
// twiddle phase (k*d) mod N and each lane's power, stage 2 reads the sine
// ROM (two ports per rotated lane), stage 3 rotates, stage 4 sums and rounds,
// stage 5 squares, stage 6 forms power and magnitude sum, and seven stages
// of a restoring divider (a capture stage, then three quotient bits in each
// of six) finish. Lane magnitudes come from a four-stage square root running
// beside stages 2 to 5.
// Configuration (log2 FFT size, lanes in use) must be written while idle.
module coherence_weighted_delay_sum_beamformer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cwb_pkg::in_beat_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output cwb_pkg::out_beat_t              out_data,
    input  logic                            cfg_we,
    input  logic [cwb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [3:0]                      cfg_data
);

    localparam int NL = cwb_pkg::NUM_LANES;

    // configuration
    logic [3:0] log2_reg;
    logic [2:0] chan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_reg <= cwb_pkg::LOG2_FFT_RESET;
            chan_reg <= cwb_pkg::CHANNELS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cwb_pkg::REG_LOG2_FFT: log2_reg <= cfg_data;
                cwb_pkg::REG_CHANNELS: chan_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // whole pipe advances together; stalls only when the output beat waits
    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // stage 1: phase index and lane power
    logic signed [15:0] xr_in [0:NL-1];
    logic signed [15:0] xi_in [0:NL-1];
    logic        [11:0] dly_in [0:NL-1];
    logic        [3:0]  log2_c;
    logic        [3:0]  shamt;

    always_comb
    begin
        xr_in[0] = in_data.mic0_real;  xi_in[0] = in_data.mic0_imag;
        xr_in[1] = in_data.mic1_real;  xi_in[1] = in_data.mic1_imag;
        xr_in[2] = in_data.mic2_real;  xi_in[2] = in_data.mic2_imag;
        xr_in[3] = in_data.mic3_real;  xi_in[3] = in_data.mic3_imag;
        dly_in[0] = '0;
        dly_in[1] = in_data.delay_mic1;
        dly_in[2] = in_data.delay_mic2;
        dly_in[3] = in_data.delay_mic3;
        if (log2_reg < 4'(cwb_pkg::MIN_LOG2_FFT))
            log2_c = 4'(cwb_pkg::MIN_LOG2_FFT);
        else if (log2_reg > 4'(cwb_pkg::MAX_LOG2_FFT))
            log2_c = 4'(cwb_pkg::MAX_LOG2_FFT);
        else
            log2_c = log2_reg;
        shamt = 4'(cwb_pkg::MAX_LOG2_FFT) - log2_c;
    end

    logic                vld1_reg;
    logic        [11:0]  bin1_reg;
    logic signed [15:0]  xr1_reg [0:NL-1];
    logic signed [15:0]  xi1_reg [0:NL-1];
    logic        [11:0]  ph1_reg [0:NL-1];
    logic        [31:0]  pw1_reg [0:NL-1];

    logic signed [15:0]  xr1_next [0:NL-1];
    logic signed [15:0]  xi1_next [0:NL-1];
    logic        [11:0]  ph1_next [0:NL-1];
    logic        [31:0]  pw1_next [0:NL-1];

    always_comb
    begin
        logic [11:0] kd;
        for (int c = 0; c < NL; c++)
        begin
            // disabled lanes are zeroed here so they add nothing downstream
            if (3'(c) < chan_reg)
            begin
                xr1_next[c] = xr_in[c];
                xi1_next[c] = xi_in[c];
            end
            else
            begin
                xr1_next[c] = '0;
                xi1_next[c] = '0;
            end
            pw1_next[c] = 32'(32'(xr1_next[c] * xr1_next[c]))
                        + 32'(32'(xi1_next[c] * xi1_next[c]));
            kd          = 12'(in_data.bin_index * dly_in[c]);
            ph1_next[c] = 12'(kd << shamt);
        end
    end

    // stage 2: ROM read (inside the ROMs), data carried along
    logic                vld2_reg;
    logic        [11:0]  bin2_reg;
    logic signed [15:0]  xr2_reg [0:NL-1];
    logic signed [15:0]  xi2_reg [0:NL-1];
    logic        [1:0]   quad2_reg [0:NL-1];
    logic [cwb_pkg::TW_W-1:0] sa2 [0:NL-1];
    logic [cwb_pkg::TW_W-1:0] sb2 [0:NL-1];

    assign sa2[0] = '0;
    assign sb2[0] = '0;

    for (genvar c = 1; c < NL; c++)
    begin : g_rom
        logic [cwb_pkg::TW_ADDR_W-1:0] addr_a;
        logic [cwb_pkg::TW_ADDR_W-1:0] addr_b;
        assign addr_a = cwb_pkg::TW_ADDR_W'(ph1_reg[c][9:0]);
        assign addr_b = cwb_pkg::TW_ADDR_W'(cwb_pkg::TW_QUART) - addr_a;
        cwb_sine_rom u_rom (
            .clk    (clk),
            .en     (adv),
            .addr_a (addr_a),
            .addr_b (addr_b),
            .data_a (sa2[c]),
            .data_b (sb2[c])
        );
    end

    // lane magnitudes, four stages beside stages 2..5
    logic [15:0] mag5 [0:NL-1];

    for (genvar c = 0; c < NL; c++)
    begin : g_sqrt
        cwb_isqrt u_sqrt (
            .clk      (clk),
            .en       (adv),
            .radicand (pw1_reg[c]),
            .root     (mag5[c])
        );
    end

    // stage 3: rotation
    logic                vld3_reg;
    logic        [11:0]  bin3_reg;
    logic signed [33:0]  ar3_reg [0:NL-1];
    logic signed [33:0]  ai3_reg [0:NL-1];
    logic signed [33:0]  ar3_next [0:NL-1];
    logic signed [33:0]  ai3_next [0:NL-1];

    always_comb
    begin
        logic signed [16:0] a;
        logic signed [16:0] b;
        logic signed [16:0] cs;
        logic signed [16:0] sn;
        for (int c = 0; c < NL; c++)
        begin
            a = 17'(sa2[c]);
            b = 17'(sb2[c]);
            case (quad2_reg[c])
                2'd0:    begin sn = a;  cs = b;  end
                2'd1:    begin sn = b;  cs = -a; end
                2'd2:    begin sn = -a; cs = -b; end
                default: begin sn = -b; cs = a;  end
            endcase
            if (c == 0)
            begin
                // reference lane passes unrotated, scaled to Q15
                ar3_next[c] = 34'(xr2_reg[c]) <<< 15;
                ai3_next[c] = 34'(xi2_reg[c]) <<< 15;
            end
            else
            begin
                ar3_next[c] = 34'(xr2_reg[c] * cs) + 34'(xi2_reg[c] * sn);
                ai3_next[c] = 34'(xi2_reg[c] * cs) - 34'(xr2_reg[c] * sn);
            end
        end
    end

    // stage 4: lane sum, round half up to integer
    logic                vld4_reg;
    logic        [11:0]  bin4_reg;
    logic signed [19:0]  sr4_reg;
    logic signed [19:0]  si4_reg;
    logic signed [35:0]  sum_r;
    logic signed [35:0]  sum_i;

    always_comb
    begin
        sum_r = 36'sd16384;
        sum_i = 36'sd16384;
        for (int c = 0; c < NL; c++)
        begin
            sum_r = sum_r + 36'(ar3_reg[c]);
            sum_i = sum_i + 36'(ai3_reg[c]);
        end
    end

    // stage 5: squares
    logic                       vld5_reg;
    logic [11:0]                bin5_reg;
    logic [cwb_pkg::POW_W-1:0]  sq_r5_reg;
    logic [cwb_pkg::POW_W-1:0]  sq_i5_reg;
    logic signed [39:0]         sq_r;
    logic signed [39:0]         sq_i;

    assign sq_r = 40'(sr4_reg * sr4_reg);
    assign sq_i = 40'(si4_reg * si4_reg);

    // stage 6: beam power and magnitude sum
    logic                          vld6_reg;
    logic [11:0]                   bin6_reg;
    logic [cwb_pkg::POW_W-1:0]     pow6_reg;
    logic [cwb_pkg::MAG_SUM_W-1:0] msum6_reg;
    logic [cwb_pkg::MAG_SUM_W-1:0] msum;

    always_comb
    begin
        msum = '0;
        for (int c = 0; c < NL; c++)
            msum = msum + cwb_pkg::MAG_SUM_W'(mag5[c]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld1_reg <= in_valid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bin1_reg <= in_data.bin_index;
            bin2_reg <= bin1_reg;
            bin3_reg <= bin2_reg;
            bin4_reg <= bin3_reg;
            bin5_reg <= bin4_reg;
            bin6_reg <= bin5_reg;
            for (int c = 0; c < NL; c++)
            begin
                xr1_reg[c]   <= xr1_next[c];
                xi1_reg[c]   <= xi1_next[c];
                ph1_reg[c]   <= ph1_next[c];
                pw1_reg[c]   <= pw1_next[c];
                xr2_reg[c]   <= xr1_reg[c];
                xi2_reg[c]   <= xi1_reg[c];
                quad2_reg[c] <= ph1_reg[c][11:10];
                ar3_reg[c]   <= ar3_next[c];
                ai3_reg[c]   <= ai3_next[c];
            end
            sr4_reg   <= 20'(sum_r >>> 15);
            si4_reg   <= 20'(sum_i >>> 15);
            sq_r5_reg <= sq_r[cwb_pkg::POW_W-1:0];
            sq_i5_reg <= sq_i[cwb_pkg::POW_W-1:0];
            pow6_reg  <= sq_r5_reg + sq_i5_reg;
            msum6_reg <= msum;
        end
    end

    // stages 7..13: divide and saturate
    cwb_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vld6_reg),
        .power     (pow6_reg),
        .mag_sum   (msum6_reg),
        .bin       (bin6_reg),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

// File: tb/sv/beam_power_checker.sv
// Checker for the beamformer: predicts each output beat and compares it.
module beam_power_checker
    import cwb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_beat_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_beat_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [3:0]            cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    results_seen
);

    int        sine_q15 [0:TW_QUART];
    out_beat_t beam_results_due [$];
    logic [3:0] fft_log2;
    logic [2:0] lanes_on;

    // quarter-wave sine, Q2.30 Taylor series rounded to Q15
    initial
    begin
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned q;
        longint          acc;
        for (int j = 0; j <= TW_QUART; j++)
        begin
            x    = (PI_Q30 * longint'(j)) / longint'(2 * TW_QUART);
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int n = 1; n <= 8; n++)
            begin
                term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
                acc  = (n % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            q = (longint'(acc) + 16384) >> 15;
            sine_q15[j] = (q > 32767) ? 32767 : int'(q);
        end
    end

    function automatic longint round_sqrt(longint unsigned v);
        longint unsigned r;
        r = longint'($sqrt(real'(v)));
        while (r * r > v)
            r--;
        while ((r + 1) * (r + 1) <= v)
            r++;
        return (v - r * r > r) ? r + 1 : r;
    endfunction

    function automatic out_beat_t beam_power_of(in_beat_t b);
        out_beat_t       o;
        int              log2n;
        int              n_mask;
        int              m;
        int              qd;
        int              rr;
        longint          cs;
        longint          sn;
        longint          xr;
        longint          xi;
        longint          acc_r;
        longint          acc_i;
        longint          sr;
        longint          si;
        longint unsigned mag;
        longint unsigned pw;
        longint unsigned quo;
        logic signed [15:0] re [4];
        logic signed [15:0] im [4];
        logic [11:0]        dl [4];
        re = '{b.mic0_real, b.mic1_real, b.mic2_real, b.mic3_real};
        im = '{b.mic0_imag, b.mic1_imag, b.mic2_imag, b.mic3_imag};
        dl = '{12'd0, b.delay_mic1, b.delay_mic2, b.delay_mic3};
        log2n = (fft_log2 < MIN_LOG2_FFT) ? MIN_LOG2_FFT :
                (fft_log2 > MAX_LOG2_FFT) ? MAX_LOG2_FFT : int'(fft_log2);
        n_mask = (1 << log2n) - 1;
        acc_r = 0;
        acc_i = 0;
        mag   = 0;
        for (int c = 0; c < NUM_LANES; c++)
        begin
            if (c >= lanes_on)
                continue;
            xr = re[c];
            xi = im[c];
            if (c == 0)
            begin
                acc_r += xr * 32768;
                acc_i += xi * 32768;
            end
            else
            begin
                m  = ((int'(b.bin_index) * int'(dl[c]) & n_mask)
                      << (MAX_LOG2_FFT - log2n)) & (TW_FULL - 1);
                qd = m / TW_QUART;
                rr = m % TW_QUART;
                case (qd)
                    0: begin sn =  sine_q15[rr];            cs =  sine_q15[TW_QUART-rr]; end
                    1: begin sn =  sine_q15[TW_QUART-rr];   cs = -sine_q15[rr];          end
                    2: begin sn = -sine_q15[rr];            cs = -sine_q15[TW_QUART-rr]; end
                    default: begin sn = -sine_q15[TW_QUART-rr]; cs = sine_q15[rr];       end
                endcase
                acc_r += xr * cs + xi * sn;
                acc_i += xi * cs - xr * sn;
            end
            mag += round_sqrt(longint'(xr * xr + xi * xi));
        end
        // round half toward +inf = floor of (v + half)
        sr  = (acc_r + 16384) >>> 15;
        si  = (acc_i + 16384) >>> 15;
        pw  = sr * sr + si * si;
        quo = (mag != 0) ? pw / mag : 0;
        o.bin_out            = b.bin_index;
        o.weighted_magnitude = (quo > OUT_MAX) ? OUT_MAX : quo[QUO_W-1:0];
        return o;
    endfunction

    assign pending = beam_results_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            fft_log2     <= LOG2_FFT_RESET;
            lanes_on     <= CHANNELS_RESET;
            errors       <= 0;
            results_seen <= 0;
            beam_results_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_LOG2_FFT)
                    fft_log2 <= cfg_data;
                else if (cfg_index == REG_CHANNELS)
                    lanes_on <= cfg_data[2:0];
            end
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (beam_results_due.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected out beat: bin %0d mag %0d",
                                 out_data.bin_out, out_data.weighted_magnitude);
                    errors <= errors + 1;
                end
                else
                begin
                    want = beam_results_due.pop_front();
                    if (want !== out_data)
                    begin
                        if (errors < 10)
                            $display("mismatch: exp bin %0d mag %0d, got bin %0d mag %0d",
                                     want.bin_out, want.weighted_magnitude,
                                     out_data.bin_out, out_data.weighted_magnitude);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                beam_results_due.push_back(beam_power_of(in_data));
        end
    end

endmodule

// File: tb/sv/tb_coherence_weighted_delay_sum_beamformer.sv
// Testbench top: stimulus, configuration phases and the verdict.
module tb_coherence_weighted_delay_sum_beamformer;
    import cwb_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_beat_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_beat_t            out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_LOG2_FFT;
    logic [3:0]           cfg_data = '0;

    int   errors;
    int   pending;
    int   results_seen;
    int   beats_sent = 0;
    int   stall_left = 0;
    // idling switch: off for quiet stretches and for the tail of the run
    logic idle_on = 1'b0;

    always #6 clk = ~clk;

    coherence_weighted_delay_sum_beamformer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    beam_power_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .errors       (errors),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // receiver back-pressure: random stall bursts while idle_on is set
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 11) == 0)
        begin
            stall_left <= $urandom_range(0, 7);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // one beat: raise valid at a rising edge and hold until taken; ready is
    // read at the falling edge, where it is settled for the coming edge
    task automatic send_bin(in_beat_t b);
        logic taken;
        in_valid <= 1'b1;
        in_data  <= b;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        beats_sent++;
        if (idle_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // hold off until every predicted beat is out, plus pipeline latency
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_config(logic [3:0] log2n, logic [2:0] lanes);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOG2_FFT;
        cfg_data  <= log2n;
        @(posedge clk);
        cfg_index <= REG_CHANNELS;
        cfg_data  <= {1'b0, lanes};
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly legal bins with random content; some beams are coherent
    // (all lanes equal, zero delay) so the power term gets large
    function automatic in_beat_t random_bin(int log2n);
        in_beat_t b;
        int       half;
        half = 1 << ((log2n < MIN_LOG2_FFT ? MIN_LOG2_FFT :
                      log2n > MAX_LOG2_FFT ? MAX_LOG2_FFT : log2n) - 1);
        b.bin_index  = ($urandom_range(0, 5) == 0) ? 12'($urandom)
                                                   : 12'($urandom_range(0, half));
        b.mic0_real  = pick_sample();
        b.mic0_imag  = pick_sample();
        b.mic1_real  = pick_sample();
        b.mic1_imag  = pick_sample();
        b.mic2_real  = pick_sample();
        b.mic2_imag  = pick_sample();
        b.mic3_real  = pick_sample();
        b.mic3_imag  = pick_sample();
        b.delay_mic1 = 12'($urandom);
        b.delay_mic2 = 12'($urandom);
        b.delay_mic3 = 12'($urandom);
        if ($urandom_range(0, 4) == 0)
        begin
            b.mic1_real = b.mic0_real;  b.mic1_imag = b.mic0_imag;
            b.mic2_real = b.mic0_real;  b.mic2_imag = b.mic0_imag;
            b.mic3_real = b.mic0_real;  b.mic3_imag = b.mic0_imag;
            b.delay_mic1 = '0;
            b.delay_mic2 = '0;
            b.delay_mic3 = '0;
        end
        return b;
    endfunction

    // directed bins at default config (N = 512, four lanes)
    task automatic directed_bins();
        in_beat_t b;
        b = '0;
        send_bin(b);                                  // all zero: no lane magnitude
        b = '{12'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
              16'h7fff, 16'h7fff, 12'd0, 12'd0, 12'd0};
        send_bin(b);                                  // fully coherent, largest
        b = '{12'd256, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
              16'h8000, 16'h8000, 12'h800, 12'h800, 12'h800};
        send_bin(b);                                  // most negative values, N/2
        b = '{12'hfff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0001, 16'hffff,
              16'h1234, 16'hedcb, 12'h7ff, 12'hfff, 12'h001};
        send_bin(b);                                  // bin past N/2, mixed delays
        b = '{12'd1, 16'd1000, 16'd0, 16'd1000, 16'd0, 16'd1000, 16'd0,
              16'd1000, 16'd0, 12'd128, 12'd256, 12'd384};
        send_bin(b);                                  // quarter-turn steps
        b = '{12'd3, 16'd5, 16'hfffb, 16'd0, 16'd0, 16'd0, 16'd0,
              16'd0, 16'd0, 12'hfff, 12'hffe, 12'hffd};
        send_bin(b);                                  // negative delays
        b = '{12'd100, 16'd1, 16'd0, 16'hffff, 16'd0, 16'd0, 16'd0,
              16'd0, 16'd0, 12'd0, 12'd0, 12'd0};
        send_bin(b);                                  // cancelling lanes, rounding
        for (int i = 0; i < 8; i++)
            send_bin(random_bin(9));
    endtask

    initial
    begin
        logic [3:0] log2_plan [8] = '{4'd4, 4'd12, 4'd0, 4'd15, 4'd7, 4'd5, 4'd12, 4'd9};
        logic [2:0] lane_plan [8] = '{3'd2, 3'd4, 3'd3, 3'd1, 3'd0, 3'd7, 3'd4, 3'd4};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_bins();
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            set_config(log2_plan[ph], lane_plan[ph]);
            // last phase runs with no idling on either side
            for (int i = 0; i < 85; i++)
            begin
                if (i % 30 == 0)
                    idle_on <= (ph < 7) && (i != 60);
                if (ph == 2 && i == 40)
                    drain();                          // sender waits for all results
                send_bin(random_bin(log2_plan[ph]));
            end
            drain();
        end

        $display("Sent %0d bins, checked %0d results over 9 settings of FFT size and lanes.",
                 beats_sent, results_seen);
        $display("Covered sizes 16 to 4096 incl. clamped codes, 0 to 7 lanes, stalls both sides.");
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2400000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/cwb_pkg.sv
rtl/cwb_sine_rom.sv
rtl/cwb_isqrt.sv
rtl/cwb_divider.sv
rtl/coherence_weighted_delay_sum_beamformer.sv
tb/sv/beam_power_checker.sv
tb/sv/tb_coherence_weighted_delay_sum_beamformer.sv
